/* rtl/core/itrd_pkg.sv */
// Package for the integer to radix digit converter.
// Holds widths, ASCII constants, the queue entry type and the digit encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itrd_pkg;

  // Width of the signed input value
  localparam int VALUE_BITS  = 32;
  localparam int BASE_W      = 6;
  // A digit is below the largest base (36), so it fits the base width
  localparam int DIGIT_W     = BASE_W;
  localparam int CHAR_W      = 7;
  // Base 2 with the most negative value gives VALUE_BITS digits
  localparam int MAX_DIGITS  = VALUE_BITS;
  localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
  localparam int PTR_W       = $clog2(MAX_DIGITS);
  localparam int BIT_W       = $clog2(VALUE_BITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BASE_W-1:0]  BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0]  BASE_MAX   = BASE_W'(36);
  localparam logic [DIGIT_W-1:0] TEN        = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  ASCII_A    = CHAR_W'(65);

  // Classified job passed from the front end to the conversion engine
  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    logic [BASE_W-1:0]     base;
    logic                  neg;
    logic                  bad;
  } job_t;

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < TEN) begin
      c = ASCII_ZERO + CHAR_W'(d);
    end else begin
      c = ASCII_A + CHAR_W'(d - TEN);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/itrd_front.sv */
// Front end of the radix converter: takes the magnitude and sign of the
// input value, and checks the base. Uses itrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itrd_front (
  input  wire logic [itrd_pkg::VALUE_BITS-1:0] value_i,
  input  wire logic [itrd_pkg::BASE_W-1:0]     base_i,
  output itrd_pkg::job_t                       job_o
);

  logic neg;

  // Take the two's complement magnitude; the most negative value wraps to 2^(N-1)
  assign neg = value_i[itrd_pkg::VALUE_BITS-1];

  always_comb begin
    job_o.mag  = neg ? (~value_i + itrd_pkg::VALUE_BITS'(1)) : value_i;
    job_o.base = base_i;
    job_o.neg  = neg;
    job_o.bad  = (base_i < itrd_pkg::BASE_MIN) || (base_i > itrd_pkg::BASE_MAX);
  end

endmodule

`default_nettype wire

/* rtl/core/itrd_fifo.sv */
// Short job queue between the front end and the conversion engine.
// Entry type and depth come from itrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itrd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire itrd_pkg::job_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output itrd_pkg::job_t      pop_data_o,
  output logic                empty_o
);

  itrd_pkg::job_t                mem_q [itrd_pkg::QUEUE_DEPTH];
  logic [itrd_pkg::Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [itrd_pkg::Q_CNT_W-1:0]  count_q;
  logic                          do_push, do_pop;

  assign full_o     = (count_q == itrd_pkg::Q_CNT_W'(itrd_pkg::QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == itrd_pkg::Q_PTR_W'(itrd_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + itrd_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == itrd_pkg::Q_PTR_W'(itrd_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + itrd_pkg::Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + itrd_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - itrd_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/itrd_back.sv */
// Conversion engine: bit-serial restoring divider, digit stack and
// output register with digit encoding. Uses itrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itrd_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire itrd_pkg::job_t                  job_i,
  input  wire logic                            job_valid_i,
  output logic                                 job_pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [itrd_pkg::CHAR_W-1:0]          out_char_o,
  output logic                                 out_neg_o,
  output logic                                 out_bad_o,
  output logic                                 out_last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                        state_q, state_d;
  logic [itrd_pkg::VALUE_BITS-1:0]   quo_q, quo_d;
  logic [itrd_pkg::DIGIT_W-1:0]      rem_q, rem_d;
  logic [itrd_pkg::BASE_W-1:0]       base_q;
  logic                              neg_q, bad_q;
  logic [itrd_pkg::BIT_W-1:0]        bit_q;
  logic [itrd_pkg::CNT_W-1:0]        n_q;
  logic [itrd_pkg::DIGIT_W-1:0]      stack_q [itrd_pkg::MAX_DIGITS];
  logic [itrd_pkg::DIGIT_W:0]        trial;
  logic                              ge;
  logic                              div_done;
  logic                              out_load;
  logic [itrd_pkg::PTR_W-1:0]        top_idx;
  logic                              out_valid_q;
  logic [itrd_pkg::CHAR_W-1:0]       out_char_q;
  logic                              out_neg_q, out_bad_q, out_last_q;

  // One restoring division step: bring down the next quotient bit
  assign trial    = {rem_q, quo_q[itrd_pkg::VALUE_BITS-1]};
  assign ge       = (trial >= {1'b0, base_q});
  assign rem_d    = ge ? itrd_pkg::DIGIT_W'(trial - {1'b0, base_q})
                       : itrd_pkg::DIGIT_W'(trial);
  assign quo_d    = {quo_q[itrd_pkg::VALUE_BITS-2:0], ge};
  assign div_done = (bit_q == itrd_pkg::BIT_W'(itrd_pkg::VALUE_BITS - 1));

  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;
  assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign top_idx   = itrd_pkg::PTR_W'(n_q - itrd_pkg::CNT_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.bad ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done && (quo_d == '0)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && (n_q == itrd_pkg::CNT_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Push remainders onto the digit stack
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DIV) && div_done) begin
      stack_q[n_q[itrd_pkg::PTR_W-1:0]] <= rem_d;
    end
  end

  // Divider datapath
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      quo_q  <= job_i.mag;
      rem_q  <= '0;
      base_q <= job_i.base;
      neg_q  <= job_i.neg;
      bad_q  <= job_i.bad;
    end else if (state_q == ST_DIV) begin
      quo_q <= quo_d;
      rem_q <= div_done ? '0 : rem_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_char_q <= bad_q ? '0 : itrd_pkg::digit_to_ascii(stack_q[top_idx]);
      out_neg_q  <= neg_q;
      out_bad_q  <= bad_q;
      out_last_q <= (n_q == itrd_pkg::CNT_W'(1));
    end
  end

  // Control: state, bit counter, digit count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (job_pop_o) begin
        bit_q <= '0;
        // A bad base yields one flagged result
        n_q   <= job_i.bad ? itrd_pkg::CNT_W'(1) : '0;
      end else if (state_q == ST_DIV) begin
        bit_q <= div_done ? '0 : bit_q + itrd_pkg::BIT_W'(1);
        if (div_done) begin
          n_q <= n_q + itrd_pkg::CNT_W'(1);
        end
      end else if (out_load) begin
        n_q <= n_q - itrd_pkg::CNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_neg_o   = out_neg_q;
  assign out_bad_o   = out_bad_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

/* rtl/core/integer_to_radix_digits.sv */
// Top level of the integer to radix digit converter.
// Instantiates itrd_front, itrd_fifo and itrd_back; uses itrd_pkg.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: value[31:0], base[37:32], zero pad [39:38]
//   m_axis    out        tdata: digit_char[6:0], pad [7]; tuser: was_negative,
//                        bad_base; tlast: last digit
//
// The bit-serial divider runs one division per digit, each through all
// VALUE_BITS quotient bits, and the digits are emitted from the stack
// after the last division. A bad base yields one flagged result.
// Reset is asynchronous, active low, and clears queue and engine control.
// A two-entry job queue lets the input side accept while the engine works,
// and the output register holds a digit while the next one is prepared.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_digits (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,   // value[31:0], base[37:32], pad
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,    // digit_char[6:0], pad[7]
  output logic [1:0]      m_axis_tuser_o,    // was_negative[0], bad_base[1]
  output logic            m_axis_tlast_o
);

  itrd_pkg::job_t              front_job, queue_job;
  logic                        queue_full, queue_empty, job_pop;
  logic [itrd_pkg::CHAR_W-1:0] out_char;
  logic                        out_neg, out_bad;

  // Classify incoming items
  itrd_front u_front (
    .value_i (s_axis_tdata_i[itrd_pkg::VALUE_BITS-1:0]),
    .base_i  (s_axis_tdata_i[itrd_pkg::VALUE_BITS +: itrd_pkg::BASE_W]),
    .job_o   (front_job)
  );

  // Queue classified jobs
  itrd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_data_i (front_job),
    .full_o      (queue_full),
    .pop_i       (job_pop),
    .pop_data_o  (queue_job),
    .empty_o     (queue_empty)
  );

  assign s_axis_tready_o = !queue_full;

  // Convert and emit digits
  itrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (queue_job),
    .job_valid_i (!queue_empty),
    .job_pop_o   (job_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_neg_o   (out_neg),
    .out_bad_o   (out_bad),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, out_char};
  assign m_axis_tuser_o = {out_bad, out_neg};

endmodule

`default_nettype wire
